/* sv/stm_pkg.sv */
// stm_pkg: shared widths, codes and result type of the signal timeout monitor
// no dependencies; used by the interfaces, the slot core and the top level
package stm_pkg;

  localparam int SLOT_COUNT      = 6;
  localparam int SIGNALS_DEFAULT = 6;
  localparam int ID_W            = 29;
  localparam int TIME_W          = 32;
  localparam int OP_W            = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(100);

  localparam logic [OP_W-1:0] OP_SEEN  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_LAST  = 3'd6;

  typedef logic [SLOT_COUNT-1:0][ID_W-1:0] id_table_t;

  typedef struct packed {
    logic                  matched;
    logic                  fault;
    logic [SLOT_COUNT-1:0] expired_mask;
    logic [ID_W-1:0]       last_fail_id;
  } stm_result_t;

endpackage

/* sv/stm_in_if.sv */
// stm_in_if: valid/ready channel carrying one monitor event
// depends on stm_pkg for field widths
interface stm_in_if;
  import stm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [ID_W-1:0]       signal_id;

  modport source (output valid, output operation, output signal_id, input ready);
  modport sink   (input valid, input operation, input signal_id, output ready);
endinterface

/* sv/stm_out_if.sv */
// stm_out_if: valid/ready channel carrying one monitor result
// depends on stm_pkg for field widths
interface stm_out_if;
  import stm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  matched;
  logic                  fault;
  logic [SLOT_COUNT-1:0] expired_mask;
  logic [ID_W-1:0]       last_fail_id;

  modport source (output valid, output matched, output fault, output expired_mask,
                  output last_fail_id, input ready);
  modport sink   (input valid, input matched, input fault, input expired_mask,
                  input last_fail_id, output ready);
endinterface

/* sv/signal_timeout_monitor_top.sv */
// signal_timeout_monitor_top: heartbeat watchdog over up to six message identifiers
// depends on stm_pkg, stm_in_if, stm_out_if and stm_core
//
// Takes one event per cycle while the result side keeps up (signal seen, time
// tick or periodic check) and returns exactly one result per event: the event
// sits in the input register, goes through the single-pass slot evaluation and
// is held in the result register, which frees the input side for a new event.
// The user must write the timeout and the watched identifiers through the cfg_
// port only while no event is in flight; the block does not enforce this.
// Slots at SIGNALS or above never match and never expire.
module signal_timeout_monitor_top #(
  parameter int SIGNALS = stm_pkg::SIGNALS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  stm_in_if.sink                           in_ch,
  stm_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [stm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stm_pkg::*;

  logic [TIME_W-1:0] timeout_r;
  id_table_t         id_r;

  logic              in_v_r;
  logic [OP_W-1:0]   in_op_r;
  logic [ID_W-1:0]   in_id_r;
  logic              out_v_r;
  stm_result_t       out_res_r;
  stm_result_t       res;
  logic              adv;
  logic              step;

  assign adv         = !out_v_r || out_ch.ready;
  assign step        = in_v_r && adv;
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      id_r      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TIMEOUT) begin
        timeout_r <= cfg_data[TIME_W-1:0];
      end else if (cfg_index >= CFG_ID_FIRST && cfg_index <= CFG_ID_LAST) begin
        id_r[cfg_index - CFG_ID_FIRST] <= cfg_data[ID_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r <= in_ch.operation;
      in_id_r <= in_ch.signal_id;
    end
  end

  stm_core #(
    .SIGNALS (SIGNALS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .op      (in_op_r),
    .sig     (in_id_r),
    .timeout (timeout_r),
    .id_slot (id_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.matched      = out_res_r.matched;
  assign out_ch.fault        = out_res_r.fault;
  assign out_ch.expired_mask = out_res_r.expired_mask;
  assign out_ch.last_fail_id = out_res_r.last_fail_id;

  a_fault_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_res_r.fault == (out_res_r.expired_mask != '0)))
    else $error("fault flag disagrees with expired mask");

  a_match_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_res_r.matched && out_res_r.fault))
    else $error("match and fault reported for one event");

  a_unused_slots: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_res_r.expired_mask >> SIGNALS) == '0))
    else $error("unused slot reported expired");

  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("evaluated event produced no result");

endmodule

/* sv/stm_core.sv */
// stm_core: time counter, per-slot timestamps and sticky failure record
// evaluates one event per step in a single pass; depends on stm_pkg
module stm_core #(
  parameter int SIGNALS = stm_pkg::SIGNALS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [stm_pkg::OP_W-1:0]       op,
  input  logic [stm_pkg::ID_W-1:0]       sig,
  input  logic [stm_pkg::TIME_W-1:0]     timeout,
  input  stm_pkg::id_table_t             id_slot,
  output stm_pkg::stm_result_t           res
);
  import stm_pkg::*;

  logic [SIGNALS-1:0][TIME_W-1:0] seen_r;
  logic [TIME_W-1:0]              time_r;
  logic [ID_W-1:0]                last_r;

  logic [SIGNALS-1:0]    hit;
  logic                  found;
  logic [SLOT_COUNT-1:0] expired;
  logic [TIME_W-1:0]     age;
  logic [ID_W-1:0]       fail_id;

  // lowest-index match wins
  always_comb begin
    hit   = '0;
    found = 1'b0;
    for (int i = 0; i < SIGNALS; i++) begin
      if (!found && id_slot[i] == sig) begin
        hit[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  // wrapping age per slot, highest expired slot sets the record
  always_comb begin
    expired = '0;
    fail_id = last_r;
    age     = '0;
    for (int i = 0; i < SIGNALS; i++) begin
      age = time_r - seen_r[i];
      if (age > timeout) begin
        expired[i] = 1'b1;
        fail_id    = id_slot[i];
      end
    end
  end

  always_comb begin
    res = '{matched: 1'b0, fault: 1'b0, expired_mask: '0, last_fail_id: last_r};
    case (op)
      OP_SEEN:  res.matched = found;
      OP_CHECK: begin
        res.fault        = |expired;
        res.expired_mask = expired;
        res.last_fail_id = fail_id;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      time_r <= '0;
      last_r <= '0;
    end else if (step) begin
      case (op)
        OP_SEEN: begin
          for (int i = 0; i < SIGNALS; i++) begin
            if (hit[i]) seen_r[i] <= time_r;
          end
        end
        OP_TICK:  time_r <= time_r + TIME_W'(1);
        OP_CHECK: last_r <= fail_id;
        default: ;
      endcase
    end
  end

endmodule

/* sim/tb_signal_timeout_monitor_top.sv */
// tb_signal_timeout_monitor_top: self-checking bench for the heartbeat watchdog top level
// depends on stm_pkg, stm_in_if, stm_out_if and signal_timeout_monitor_top
// a scoreboard class predicts each report; random stalls on both channels
`timescale 1ns / 1ps

module tb_signal_timeout_monitor_top;
  import stm_pkg::*;

  localparam int SIGNALS         = SIGNALS_DEFAULT;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int BURST_ITEMS     = 40;
  localparam int LONG_HOLD       = 80;
  localparam int STALL_LIMIT     = 2000;
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [ID_W-1:0]      ID_MAX     = {ID_W{1'b1}};

  class heartbeat_scoreboard;
    logic [TIME_W-1:0] timeout_ticks;
    logic [ID_W-1:0]   watched_id [SLOT_COUNT];
    logic [TIME_W-1:0] seen_stamp [SLOT_COUNT];
    logic [TIME_W-1:0] tick_count;
    logic [ID_W-1:0]   last_expired_id;
    stm_result_t       expected_reports [$];
    int errors;
    int events;
    int seen_hits;
    int faults;

    function new();
      timeout_ticks   = TIMEOUT_RESET;
      tick_count      = '0;
      last_expired_id = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        watched_id[i] = '0;
        seen_stamp[i] = '0;
      end
      errors    = 0;
      events    = 0;
      seen_hits = 0;
      faults    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TIMEOUT) begin
        timeout_ticks = data[TIME_W-1:0];
      end else if (idx >= CFG_ID_FIRST && idx <= CFG_ID_LAST) begin
        watched_id[idx - CFG_ID_FIRST] = data[ID_W-1:0];
      end
    endfunction

    function void note_event(logic [OP_W-1:0] op, logic [ID_W-1:0] sig);
      stm_result_t       rpt;
      bit                hit;
      logic [TIME_W-1:0] age;
      rpt = '0;
      hit = 1'b0;
      case (op)
        OP_SEEN: begin
          for (int i = 0; i < SIGNALS; i++) begin
            if (!hit && watched_id[i] == sig) begin
              seen_stamp[i] = tick_count;
              hit = 1'b1;
            end
          end
        end
        OP_TICK: begin
          tick_count = tick_count + 1'b1;
        end
        OP_CHECK: begin
          for (int i = 0; i < SIGNALS; i++) begin
            age = tick_count - seen_stamp[i];
            if (age > timeout_ticks) begin
              rpt.expired_mask[i] = 1'b1;
              last_expired_id = watched_id[i];
            end
          end
          rpt.fault = |rpt.expired_mask;
        end
        default: ;
      endcase
      rpt.matched      = hit;
      rpt.last_fail_id = last_expired_id;
      seen_hits += hit;
      faults    += rpt.fault;
      events++;
      expected_reports.push_back(rpt);
    endfunction

    function void check_report(stm_result_t got);
      stm_result_t want;
      if (expected_reports.size() == 0) begin
        $error("report with no pending event: %h", got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.matched !== want.matched) begin
        $error("matched: expected %0d actual %0d", want.matched, got.matched);
        errors++;
      end
      if (got.fault !== want.fault) begin
        $error("fault: expected %0d actual %0d", want.fault, got.fault);
        errors++;
      end
      if (got.expired_mask !== want.expired_mask) begin
        $error("expired_mask: expected %b actual %b", want.expired_mask, got.expired_mask);
        errors++;
      end
      if (got.last_fail_id !== want.last_fail_id) begin
        $error("last_fail_id: expected %h actual %h", want.last_fail_id, got.last_fail_id);
        errors++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stm_in_if  in_bus ();
  stm_out_if out_bus ();

  heartbeat_scoreboard sb = new();

  logic [ID_W-1:0] phase_ids [SLOT_COUNT];
  bit quiet;
  bit long_hold_req;
  int stuck_cycles;
  int config_phases;

  signal_timeout_monitor_top #(.SIGNALS(SIGNALS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      sb.note_event(in_bus.operation, in_bus.signal_id);
    end
  end

  always @(posedge clk) begin
    stm_result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.matched      = out_bus.matched;
      got.fault        = out_bus.fault;
      got.expired_mask = out_bus.expired_mask;
      got.last_fail_id = out_bus.last_fail_id;
      sb.check_report(got);
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("signal_timeout_monitor_top verification failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (quiet) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  task automatic send_event(input logic [OP_W-1:0] op, input logic [ID_W-1:0] sig,
                            input int gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.signal_id <= sig;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_directed(input logic [OP_W-1:0] op, input logic [ID_W-1:0] sig);
    send_event(op, sig, $urandom_range(0, 3));
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // upper data bits above the id width are random and must be dropped
  task automatic apply_config(input logic [TIME_W-1:0] tmo);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      write_reg(CFG_IDX_W'(CFG_ID_FIRST + i), {3'($urandom), phase_ids[i]});
    end
    write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_TIMEOUT, tmo);
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ID_MAX;
    return ID_W'($urandom);
  endfunction

  task automatic random_event(input bit burst);
    int r;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] sig;
    r   = $urandom_range(0, 99);
    sig = ID_W'($urandom);
    if (r < 40) begin
      op = OP_SEEN;
      if ($urandom_range(0, 4) != 0) sig = phase_ids[$urandom_range(0, SLOT_COUNT - 1)];
    end else if (r < 75) begin
      op = OP_TICK;
    end else if (r < 95) begin
      op = OP_CHECK;
    end else begin
      op = OP_UNUSED;
    end
    send_event(op, sig, (burst || quiet) ? 0 : $urandom_range(0, 10));
  endtask

  initial begin
    logic [TIME_W-1:0] tmo;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    stuck_cycles  = 0;
    config_phases = 0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_SEEN;
    in_bus.signal_id <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: all slots watch id zero, only the lowest one updates
    send_directed(OP_SEEN, '0);
    send_directed(OP_SEEN, ID_MAX);
    send_directed(OP_TICK, ID_MAX);
    send_directed(OP_CHECK, '0);
    send_directed(OP_UNUSED, ID_MAX);
    settle();

    // zero timeout, duplicate ids and extreme ids
    phase_ids[0] = ID_MAX;
    phase_ids[1] = 29'd5;
    phase_ids[2] = 29'd5;
    phase_ids[3] = '0;
    phase_ids[4] = 29'h0AAAAAAA;
    phase_ids[5] = 29'h15555555;
    apply_config('0);
    send_directed(OP_TICK, '0);
    send_directed(OP_CHECK, ID_MAX);
    send_directed(OP_SEEN, 29'd5);
    send_directed(OP_CHECK, '0);
    send_directed(OP_SEEN, ID_MAX);
    send_directed(OP_SEEN, 29'h15555555);
    send_directed(OP_CHECK, '0);
    send_directed(OP_UNUSED, ID_MAX);
    send_directed(OP_CHECK, '0);
    send_directed(OP_TICK, '0);
    send_directed(OP_SEEN, 29'h1234567);
    send_directed(OP_CHECK, '0);
    settle();

    // largest timeout: nothing can expire
    apply_config({TIME_W{1'b1}});
    send_directed(OP_TICK, '0);
    send_directed(OP_TICK, ID_MAX);
    send_directed(OP_CHECK, '0);
    send_directed(OP_SEEN, '0);
    send_directed(OP_CHECK, ID_MAX);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        phase_ids[i] = (i > 0 && $urandom_range(0, 3) == 0) ? phase_ids[i-1] : pick_id();
      end
      case (p % 6)
        0: tmo = '0;
        1: tmo = 32'd1;
        2: tmo = $urandom_range(2, 30);
        3: tmo = {TIME_W{1'b1}};
        4: tmo = $urandom_range(5, 60);
        default: tmo = $urandom;
      endcase
      apply_config(tmo);
      quiet = (p == 3);
      if (p == 6) long_hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_event(p == 6 && k < BURST_ITEMS);
      end
    end
    settle();
    repeat (6) @(posedge clk);

    $display("covered %0d events over %0d register settings", sb.events, config_phases);
    $display("seen hits %0d, fault reports %0d", sb.seen_hits, sb.faults);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("signal_timeout_monitor_top verification clean");
    end else begin
      $display("signal_timeout_monitor_top verification failed");
    end
    $finish;
  end

endmodule
